// ----- rtl/rsp_pkg.sv -----
`default_nettype none

package rsp_pkg;

  // Default geometry and number format
  localparam int unsigned ImgWidthDef  = 1024;
  localparam int unsigned ImgHeightDef = 768;
  localparam int unsigned FracBitsDef  = 16;

  // Field widths
  localparam int unsigned ColW    = 10;
  localparam int unsigned RowW    = 10;
  localparam int unsigned CoordW  = 32;
  localparam int unsigned RadiusW = 31;
  localparam int unsigned ColorW  = 24;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned DistW   = 31;
  localparam int unsigned CfgIdxW = 3;

  // Ray vector magnitudes stay below 2^13 for images up to 4096 pixels a side
  localparam int unsigned MagW = 13;
  localparam int unsigned SqW  = 2 * MagW;
  // Closest-approach distance never exceeds |center| < 2^32
  localparam int unsigned TcaW = 32;
  localparam int unsigned LlW  = 64;
  localparam int unsigned R2W  = 2 * RadiusW;

  localparam logic signed [CoordW-1:0] CenterXRst = -32'sd196608;
  localparam logic signed [CoordW-1:0] CenterYRst = 32'sd393216;
  localparam logic signed [CoordW-1:0] CenterZRst = -32'sd851968;
  localparam logic [RadiusW-1:0]       RadiusRst  = 31'd327680;
  localparam logic [ColorW-1:0]        HitColRst  = 24'h66664D;
  localparam logic [ColorW-1:0]        MissColRst = 24'h33B3CC;
  localparam logic [DistW-1:0]         DistMax    = {DistW{1'b1}};

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CENTER_X   = 3'd0,
    CFG_CENTER_Y   = 3'd1,
    CFG_CENTER_Z   = 3'd2,
    CFG_RADIUS     = 3'd3,
    CFG_HIT_COLOR  = 3'd4,
    CFG_MISS_COLOR = 3'd5
  } rsp_cfg_e;

  typedef struct packed {
    logic [ColW-1:0] pixel_col;
    logic [RowW-1:0] pixel_row;
  } rsp_in_t;

  typedef struct packed {
    logic [ColW-1:0]  out_col;
    logic [RowW-1:0]  out_row;
    logic             hit;
    logic [DistW-1:0] distance;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rsp_out_t;

endpackage

`default_nettype wire

// ----- rtl/rsp_div_pipe.sv -----
`default_nettype none

// Restoring fractional divider, one quotient bit per stage.
// quo = floor(num * 2^FracSteps / den), valid for num <= den.
module rsp_div_pipe import rsp_pkg::*; #(
  parameter int unsigned Lanes     = 3,
  parameter int unsigned DenW      = SqW,
  parameter int unsigned FracSteps = 2 * FracBitsDef,
  parameter int unsigned SideW     = 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic [Lanes-1:0][DenW-1:0]       num_i,
  input  logic [DenW-1:0]                  den_i,
  input  logic [SideW-1:0]                 side_i,
  output logic                             valid_o,
  output logic [Lanes-1:0][FracSteps:0]    quo_o,
  output logic [SideW-1:0]                 side_o
);

  localparam int unsigned Stages = FracSteps + 1;

  logic                          valid_q [Stages];
  logic [DenW-1:0]               den_q   [Stages];
  logic [SideW-1:0]              side_q  [Stages];
  logic [Lanes-1:0][DenW-1:0]    rem_q   [Stages];
  logic [Lanes-1:0][FracSteps:0] quo_q   [Stages];

  for (genvar k = 0; k < Stages; k++) begin : g_stage
    logic                          valid_s;
    logic [DenW-1:0]               den_s;
    logic [SideW-1:0]              side_s;
    logic [Lanes-1:0][DenW:0]      shift_s;
    logic [Lanes-1:0][FracSteps:0] quo_s;
    logic [Lanes-1:0][DenW-1:0]    rem_d;
    logic [Lanes-1:0][FracSteps:0] quo_d;

    if (k == 0) begin : g_src_in
      assign valid_s = valid_i;
      assign den_s   = den_i;
      assign side_s  = side_i;
      for (genvar l = 0; l < Lanes; l++) begin : g_lane
        assign shift_s[l] = {1'b0, num_i[l]};
        assign quo_s[l]   = '0;
      end
    end else begin : g_src_prev
      assign valid_s = valid_q[k-1];
      assign den_s   = den_q[k-1];
      assign side_s  = side_q[k-1];
      for (genvar l = 0; l < Lanes; l++) begin : g_lane
        assign shift_s[l] = {rem_q[k-1][l], 1'b0};
        assign quo_s[l]   = quo_q[k-1][l];
      end
    end

    for (genvar l = 0; l < Lanes; l++) begin : g_lane_step
      logic ge;
      logic [DenW:0] diff;
      assign diff       = shift_s[l] - {1'b0, den_s};
      assign ge         = shift_s[l] >= {1'b0, den_s};
      assign rem_d[l]   = ge ? diff[DenW-1:0] : shift_s[l][DenW-1:0];
      assign quo_d[l]   = {quo_s[l][FracSteps-1:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k]  <= den_s;
        side_q[k] <= side_s;
        rem_q[k]  <= rem_d;
        quo_q[k]  <= quo_d;
      end
    end
  end

  assign valid_o = valid_q[Stages-1];
  assign quo_o   = quo_q[Stages-1];
  assign side_o  = side_q[Stages-1];

endmodule

`default_nettype wire

// ----- rtl/rsp_isqrt_pipe.sv -----
`default_nettype none

// Digit-by-digit integer square root, one root bit per stage.
module rsp_isqrt_pipe import rsp_pkg::*; #(
  parameter int unsigned Lanes = 1,
  parameter int unsigned RootW = FracBitsDef + 1,
  parameter int unsigned SideW = 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic [Lanes-1:0][2*RootW-1:0]    x_i,
  input  logic [SideW-1:0]                 side_i,
  output logic                             valid_o,
  output logic [Lanes-1:0][RootW-1:0]      root_o,
  output logic [SideW-1:0]                 side_o
);

  localparam int unsigned XW   = 2 * RootW;
  localparam int unsigned RemW = RootW + 1;

  logic                          valid_q [RootW];
  logic [SideW-1:0]              side_q  [RootW];
  logic [Lanes-1:0][XW-1:0]      x_q     [RootW];
  logic [Lanes-1:0][RemW-1:0]    rem_q   [RootW];
  logic [Lanes-1:0][RootW-1:0]   root_q  [RootW];

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    logic                        valid_s;
    logic [SideW-1:0]            side_s;
    logic [Lanes-1:0][XW-1:0]    x_s;
    logic [Lanes-1:0][RemW-1:0]  rem_s;
    logic [Lanes-1:0][RootW-1:0] root_s;
    logic [Lanes-1:0][XW-1:0]    x_d;
    logic [Lanes-1:0][RemW-1:0]  rem_d;
    logic [Lanes-1:0][RootW-1:0] root_d;

    if (k == 0) begin : g_src_in
      assign valid_s = valid_i;
      assign side_s  = side_i;
      assign x_s     = x_i;
      assign rem_s   = '0;
      assign root_s  = '0;
    end else begin : g_src_prev
      assign valid_s = valid_q[k-1];
      assign side_s  = side_q[k-1];
      assign x_s     = x_q[k-1];
      assign rem_s   = rem_q[k-1];
      assign root_s  = root_q[k-1];
    end

    for (genvar l = 0; l < Lanes; l++) begin : g_lane
      logic [RemW+1:0] cand;
      logic [RemW+1:0] trial;
      logic [RemW+1:0] diff;
      logic            ge;
      assign cand      = {rem_s[l], x_s[l][XW-1 -: 2]};
      assign trial     = {1'b0, root_s[l], 2'b01};
      assign diff      = cand - trial;
      assign ge        = cand >= trial;
      assign rem_d[l]  = ge ? diff[RemW-1:0] : cand[RemW-1:0];
      assign root_d[l] = {root_s[l][RootW-2:0], ge};
      assign x_d[l]    = {x_s[l][XW-3:0], 2'b00};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= side_s;
        x_q[k]    <= x_d;
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
      end
    end
  end

  assign valid_o = valid_q[RootW-1];
  assign root_o  = root_q[RootW-1];
  assign side_o  = side_q[RootW-1];

endmodule

`default_nettype wire

// ----- rtl/ray_sphere_pixel_caster.sv -----
`default_nettype none

// Ray-sphere pixel caster.
// Input channel (in_valid_i / in_stall_o / in_data_i): one transfer per pixel,
// carrying its column and row. Output channel (out_valid_o / out_stall_i /
// out_data_o): one transfer per pixel, in input order, with the pixel echoed,
// the hit flag, the nearest non-negative distance (Q format, saturating, zero
// on a miss) and the chosen colour split into red, green and blue.
// Configuration: write cfg_wdata_i to register cfg_idx_i while cfg_we_i is
// high; write only while no pixel is in flight. Unknown indexes are ignored.
// Pipeline stages from input transfer to output valid: ray set-up (3),
// fractional divider (2*F+1), normalising square root (F+1), dot
// products and sphere test (5), half-chord square root (31) and the
// output register (1).
// Throughput: one pixel per cycle unless the output stalls; every stage is a fixed pipeline step.
// Stall: while the output register holds an untaken result and out_stall_i
// is high, the whole pipeline holds and in_stall_o is raised.
// Reset: clears all valid bits and loads the default sphere and colours.
module ray_sphere_pixel_caster import rsp_pkg::*; #(
  parameter int unsigned IMG_WIDTH  = ImgWidthDef,
  parameter int unsigned IMG_HEIGHT = ImgHeightDef,
  parameter int unsigned FRAC_BITS  = FracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rsp_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rsp_out_t            out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CoordW-1:0]   cfg_wdata_i
);

  localparam int unsigned QW      = 2 * FRAC_BITS;       // fractional quotient bits
  localparam int unsigned NRootW  = FRAC_BITS + 1;       // normalised magnitude
  localparam int unsigned DirW    = FRAC_BITS + 2;       // signed direction
  localparam int unsigned ProdW   = CoordW + DirW;
  localparam int unsigned DotW    = ProdW + 2;
  localparam int unsigned NSideW  = ColW + RowW + 3;
  localparam int unsigned TSideW  = ColW + RowW + 1 + TcaW;
  localparam int unsigned AW      = MagW + 2;

  localparam logic [AW-1:0]   ImgW   = AW'(IMG_WIDTH);
  localparam logic [AW-1:0]   ImgH   = AW'(IMG_HEIGHT);
  localparam logic [MagW-1:0] MagC   = MagW'(IMG_HEIGHT);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic signed [CoordW-1:0] cx_q, cy_q, cz_q;
  logic [RadiusW-1:0]       radius_q;
  logic [ColorW-1:0]        hit_col_q, miss_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q       <= CenterXRst;
      cy_q       <= CenterYRst;
      cz_q       <= CenterZRst;
      radius_q   <= RadiusRst;
      hit_col_q  <= HitColRst;
      miss_col_q <= MissColRst;
    end else if (cfg_we_i) begin
      case (rsp_cfg_e'(cfg_idx_i))
        CFG_CENTER_X:   cx_q       <= cfg_wdata_i;
        CFG_CENTER_Y:   cy_q       <= cfg_wdata_i;
        CFG_CENTER_Z:   cz_q       <= cfg_wdata_i;
        CFG_RADIUS:     radius_q   <= cfg_wdata_i[RadiusW-1:0];
        CFG_HIT_COLOR:  hit_col_q  <= cfg_wdata_i[ColorW-1:0];
        CFG_MISS_COLOR: miss_col_q <= cfg_wdata_i[ColorW-1:0];
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Global advance: the pipeline moves unless a result waits at a stalled
  // output. Stages carry their own valid bits, so bubbles flow through.
  // ---------------------------------------------------------------------
  logic     en;
  logic     out_valid_q;
  rsp_out_t out_q;

  assign en          = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------
  // Stage 1: ray vector a = 2c+1-W, b = H-2r-1, c = -H (magnitude, sign)
  // ---------------------------------------------------------------------
  logic [AW-1:0] a_raw, b_raw, a_abs, b_abs;

  assign a_raw = {4'b0, in_data_i.pixel_col, 1'b1} - ImgW;
  assign b_raw = ImgH - {4'b0, in_data_i.pixel_row, 1'b1};
  assign a_abs = a_raw[AW-1] ? AW'(-a_raw) : a_raw;
  assign b_abs = b_raw[AW-1] ? AW'(-b_raw) : b_raw;

  logic                      s1_valid_q;
  logic [ColW-1:0]           s1_col_q;
  logic [RowW-1:0]           s1_row_q;
  logic [2:0][MagW-1:0]      s1_mag_q;
  logic [2:0]                s1_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_col_q    <= in_data_i.pixel_col;
      s1_row_q    <= in_data_i.pixel_row;
      s1_mag_q[0] <= a_abs[MagW-1:0];
      s1_mag_q[1] <= b_abs[MagW-1:0];
      s1_mag_q[2] <= MagC;
      s1_neg_q    <= {1'b1, b_raw[AW-1], a_raw[AW-1]};
    end
  end

  // Stage 2: squares
  logic                 s2_valid_q;
  logic [NSideW-1:0]    s2_side_q;
  logic [2:0][SqW-1:0]  s2_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_side_q <= {s1_col_q, s1_row_q, s1_neg_q};
      for (int i = 0; i < 3; i++) begin
        s2_sq_q[i] <= s1_mag_q[i] * s1_mag_q[i];
      end
    end
  end

  // Stage 3: squared length of the ray
  logic                 s3_valid_q;
  logic [NSideW-1:0]    s3_side_q;
  logic [2:0][SqW-1:0]  s3_sq_q;
  logic [SqW-1:0]       s3_len2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_side_q <= s2_side_q;
      s3_sq_q   <= s2_sq_q;
      s3_len2_q <= s2_sq_q[0] + s2_sq_q[1] + s2_sq_q[2];
    end
  end

  // ---------------------------------------------------------------------
  // Normalise: |d_i| = floor(sqrt(v_i^2 * 2^(2F) / |v|^2))
  // ---------------------------------------------------------------------
  logic                   dv_valid;
  logic [2:0][QW:0]       dv_quo;
  logic [NSideW-1:0]      dv_side;
  logic [2:0][QW+1:0]     sq_in;

  rsp_div_pipe #(
    .Lanes     (3),
    .DenW      (SqW),
    .FracSteps (QW),
    .SideW     (NSideW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s3_valid_q),
    .num_i   (s3_sq_q),
    .den_i   (s3_len2_q),
    .side_i  (s3_side_q),
    .valid_o (dv_valid),
    .quo_o   (dv_quo),
    .side_o  (dv_side)
  );

  for (genvar i = 0; i < 3; i++) begin : g_pad
    assign sq_in[i] = {1'b0, dv_quo[i]};
  end

  logic                     nr_valid;
  logic [2:0][NRootW-1:0]   nr_root;
  logic [NSideW-1:0]        nr_side;

  rsp_isqrt_pipe #(
    .Lanes (3),
    .RootW (NRootW),
    .SideW (NSideW)
  ) u_norm_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv_valid),
    .x_i     (sq_in),
    .side_i  (dv_side),
    .valid_o (nr_valid),
    .root_o  (nr_root),
    .side_o  (nr_side)
  );

  // Reattach the signs
  logic signed [DirW-1:0] dir [3];

  for (genvar i = 0; i < 3; i++) begin : g_dir
    logic [DirW-1:0] pos;
    assign pos    = {1'b0, nr_root[i]};
    assign dir[i] = nr_side[i] ? $signed(DirW'(-pos)) : $signed(pos);
  end

  // ---------------------------------------------------------------------
  // Stage 4: component products L.d, |L|^2 terms, r^2
  // ---------------------------------------------------------------------
  logic                     s4_valid_q;
  logic [ColW+RowW-1:0]     s4_pix_q;
  logic signed [ProdW-1:0]  s4_prod_q [3];
  logic [LlW-1:0]           s4_csq_q  [3];
  logic [R2W-1:0]           s4_r2_q;
  logic signed [CoordW-1:0] ctr [3];

  assign ctr[0] = cx_q;
  assign ctr[1] = cy_q;
  assign ctr[2] = cz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (en) begin
      s4_valid_q <= nr_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_pix_q <= nr_side[NSideW-1:3];
      s4_r2_q  <= radius_q * radius_q;
      for (int i = 0; i < 3; i++) begin
        s4_prod_q[i] <= ctr[i] * dir[i];
        s4_csq_q[i]  <= LlW'(ctr[i] * ctr[i]);
      end
    end
  end

  // Stage 5: sums
  logic                    s5_valid_q;
  logic [ColW+RowW-1:0]    s5_pix_q;
  logic signed [DotW-1:0]  s5_dot_q;
  logic [LlW-1:0]          s5_ll_q;
  logic [R2W-1:0]          s5_r2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_valid_q <= 1'b0;
    end else if (en) begin
      s5_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_pix_q <= s4_pix_q;
      s5_r2_q  <= s4_r2_q;
      s5_dot_q <= DotW'(s4_prod_q[0]) + DotW'(s4_prod_q[1]) + DotW'(s4_prod_q[2]);
      s5_ll_q  <= s4_csq_q[0] + s4_csq_q[1] + s4_csq_q[2];
    end
  end

  // Stage 6: tca = dot >> F, behind-origin flag
  logic                  s6_valid_q;
  logic [ColW+RowW-1:0]  s6_pix_q;
  logic                  s6_behind_q;
  logic [TcaW-1:0]       s6_tca_q;
  logic [LlW-1:0]        s6_ll_q;
  logic [R2W-1:0]        s6_r2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_valid_q <= 1'b0;
    end else if (en) begin
      s6_valid_q <= s5_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_pix_q    <= s5_pix_q;
      s6_behind_q <= s5_dot_q[DotW-1];
      s6_tca_q    <= s5_dot_q[FRAC_BITS +: TcaW];
      s6_ll_q     <= s5_ll_q;
      s6_r2_q     <= s5_r2_q;
    end
  end

  // Stage 7: tca^2
  logic                  s7_valid_q;
  logic [ColW+RowW-1:0]  s7_pix_q;
  logic                  s7_behind_q;
  logic [TcaW-1:0]       s7_tca_q;
  logic [LlW-1:0]        s7_ll_q;
  logic [LlW-1:0]        s7_t2_q;
  logic [R2W-1:0]        s7_r2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_valid_q <= 1'b0;
    end else if (en) begin
      s7_valid_q <= s6_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_pix_q    <= s6_pix_q;
      s7_behind_q <= s6_behind_q;
      s7_tca_q    <= s6_tca_q;
      s7_ll_q     <= s6_ll_q;
      s7_t2_q     <= s6_tca_q * s6_tca_q;
      s7_r2_q     <= s6_r2_q;
    end
  end

  // Stage 8: d^2 against r^2, half-chord squared
  logic [LlW-1:0] d2;
  logic           near_hit;

  assign d2       = (s7_ll_q > s7_t2_q) ? (s7_ll_q - s7_t2_q) : '0;
  assign near_hit = !s7_behind_q && (d2 <= LlW'(s7_r2_q));

  logic                  s8_valid_q;
  logic [TSideW-1:0]     s8_side_q;
  logic [R2W-1:0]        s8_rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_valid_q <= 1'b0;
    end else if (en) begin
      s8_valid_q <= s7_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s8_side_q <= {s7_pix_q, near_hit, s7_tca_q};
      s8_rad_q  <= near_hit ? (s7_r2_q - d2[R2W-1:0]) : '0;
    end
  end

  // Half-chord length thc = floor(sqrt(r^2 - d^2))
  logic                    hc_valid;
  logic [0:0][RadiusW-1:0] hc_root;
  logic [TSideW-1:0]       hc_side;
  logic [0:0][R2W-1:0]     hc_in;

  assign hc_in[0] = s8_rad_q;

  rsp_isqrt_pipe #(
    .Lanes (1),
    .RootW (RadiusW),
    .SideW (TSideW)
  ) u_chord_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s8_valid_q),
    .x_i     (hc_in),
    .side_i  (s8_side_q),
    .valid_o (hc_valid),
    .root_o  (hc_root),
    .side_o  (hc_side)
  );

  // ---------------------------------------------------------------------
  // Output: pick the near or far crossing, saturate, choose colour
  // ---------------------------------------------------------------------
  logic [TcaW-1:0]   f_tca;
  logic [TcaW-1:0]   f_thc;
  logic              f_hit;
  logic [TcaW:0]     f_t;
  logic [DistW-1:0]  f_dist;
  logic [ColorW-1:0] f_col;

  assign f_tca  = hc_side[TcaW-1:0];
  assign f_hit  = hc_side[TcaW];
  assign f_thc  = {1'b0, hc_root[0]};
  assign f_t    = (f_tca >= f_thc) ? {1'b0, f_tca - f_thc}
                                   : ({1'b0, f_tca} + {1'b0, f_thc});
  assign f_dist = !f_hit ? '0
                : (f_t > (TcaW+1)'(DistMax)) ? DistMax : f_t[DistW-1:0];
  assign f_col  = f_hit ? hit_col_q : miss_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= hc_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.out_col  <= hc_side[TSideW-1 -: ColW];
      out_q.out_row  <= hc_side[TcaW+RowW:TcaW+1];
      out_q.hit      <= f_hit;
      out_q.distance <= f_dist;
      out_q.red      <= f_col[23:16];
      out_q.green    <= f_col[15:8];
      out_q.blue     <= f_col[7:0];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rsp_checker.sv -----
`default_nettype none

module rsp_checker import rsp_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input rsp_out_t out_data_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // A miss reports zero distance
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.hit |-> out_data_o.distance == '0)
    else $error("miss with non-zero distance");

  // Input stalls only behind a stalled, full output
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // A taken result frees the input at once
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && in_valid_i |-> !in_stall_o)
    else $error("input stalled while output drains");

endmodule

bind ray_sphere_pixel_caster rsp_checker u_rsp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// ----- tb/tb_ray_sphere_pixel_caster.sv -----
module tb_ray_sphere_pixel_caster;
  import rsp_pkg::*;

  localparam int unsigned Latency    = 3 * FracBitsDef + 42;
  localparam int unsigned DrainWait  = Latency + 20;
  localparam int unsigned CycleLimit = 400000;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  rsp_in_t            in_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  rsp_out_t           out_data_o;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CoordW-1:0]  cfg_wdata_i;

  ray_sphere_pixel_caster u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Shadow copy of the sphere and colour registers
  longint          sph_cx, sph_cy, sph_cz;
  longint unsigned sph_rad;
  logic [23:0]     col_hit, col_miss;

  rsp_out_t pending_pixels[$];
  int       n_errors;
  int       cycle_cnt;

  // Idle controls, percent of cycles
  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("[ray_sphere_pixel_caster] ERROR");
      $finish;
    end
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v  -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // sign(v) * floor(|v| * 2^F / sqrt(s)), exact via long division then root
  function automatic longint unit_comp(longint v, longint unsigned s);
    longint unsigned mag, q, r;
    mag = (v < 0) ? -v : v;
    q   = (mag * mag) / s;
    r   = (mag * mag) % s;
    for (int k = 0; k < 2 * FracBitsDef; k++) begin
      r <<= 1;
      q <<= 1;
      if (r >= s) begin
        r -= s;
        q |= 64'd1;
      end
    end
    q = int_sqrt(q);
    return (v < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned sq_abs(longint v);
    longint unsigned m;
    m = (v < 0) ? -v : v;
    return m * m;
  endfunction

  // Cast the pixel's ray and intersect it with the shadow sphere
  function automatic rsp_out_t cast_pixel(rsp_in_t px);
    longint          a, b, c, dx, dy, dz, dotp;
    longint unsigned s, tca, ll, t2, d2, r2, thc, t;
    rsp_out_t        res;
    logic [23:0]     colour;
    a = 2 * longint'(px.pixel_col) + 1 - longint'(ImgWidthDef);
    b = longint'(ImgHeightDef) - 2 * longint'(px.pixel_row) - 1;
    c = -longint'(ImgHeightDef);
    s = a * a + b * b + c * c;
    dx = unit_comp(a, s);
    dy = unit_comp(b, s);
    dz = unit_comp(c, s);
    dotp = sph_cx * dx + sph_cy * dy + sph_cz * dz;
    res = '0;
    res.out_col = px.pixel_col;
    res.out_row = px.pixel_row;
    if (dotp >= 0) begin
      tca = longint'(dotp) >>> FracBitsDef;
      ll  = sq_abs(sph_cx) + sq_abs(sph_cy) + sq_abs(sph_cz);
      t2  = tca * tca;
      d2  = (ll > t2) ? ll - t2 : 64'd0;
      r2  = sph_rad * sph_rad;
      if (d2 <= r2) begin
        thc = int_sqrt(r2 - d2);
        t   = (tca >= thc) ? tca - thc : tca + thc;
        res.hit      = 1'b1;
        res.distance = (t > 64'h7FFF_FFFF) ? DistMax : t[DistW-1:0];
      end
    end
    colour = res.hit ? col_hit : col_miss;
    {res.red, res.green, res.blue} = colour;
    return res;
  endfunction

  // Receiver: long hold-off if requested, else random stalls
  always @(negedge clk_i) begin
    if (rx_hold_left > 0) begin
      out_stall_i  <= 1'b1;
      rx_hold_left <= rx_hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Compare every output transfer against the oldest prediction
  always @(posedge clk_i) begin
    rsp_out_t exp_px;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected result col=%0d row=%0d", out_data_o.out_col, out_data_o.out_row);
        n_errors++;
      end else begin
        exp_px = pending_pixels.pop_front();
        if (out_data_o.out_col !== exp_px.out_col) begin
          $error("out_col exp %0d got %0d", exp_px.out_col, out_data_o.out_col);
          n_errors++;
        end
        if (out_data_o.out_row !== exp_px.out_row) begin
          $error("out_row exp %0d got %0d", exp_px.out_row, out_data_o.out_row);
          n_errors++;
        end
        if (out_data_o.hit !== exp_px.hit) begin
          $error("hit exp %0d got %0d", exp_px.hit, out_data_o.hit);
          n_errors++;
        end
        if (out_data_o.distance !== exp_px.distance) begin
          $error("distance exp %0d got %0d", exp_px.distance, out_data_o.distance);
          n_errors++;
        end
        if (out_data_o.red !== exp_px.red) begin
          $error("red exp %0d got %0d", exp_px.red, out_data_o.red);
          n_errors++;
        end
        if (out_data_o.green !== exp_px.green) begin
          $error("green exp %0d got %0d", exp_px.green, out_data_o.green);
          n_errors++;
        end
        if (out_data_o.blue !== exp_px.blue) begin
          $error("blue exp %0d got %0d", exp_px.blue, out_data_o.blue);
          n_errors++;
        end
      end
    end
  end

  // Offer one pixel; hold it until the transfer, then record the prediction
  task automatic send_pixel(logic [ColW-1:0] col, logic [RowW-1:0] row);
    rsp_in_t px;
    px.pixel_col = col;
    px.pixel_row = row;
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    pending_pixels.push_back(cast_pixel(px));
  endtask

  task automatic tx_release();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Drop valid, wait for every result, then let the pipe empty fully
  task automatic drain();
    tx_release();
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_reg(rsp_cfg_e idx, logic [CoordW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_CENTER_X:   sph_cx   = longint'($signed(val));
      CFG_CENTER_Y:   sph_cy   = longint'($signed(val));
      CFG_CENTER_Z:   sph_cz   = longint'($signed(val));
      CFG_RADIUS:     sph_rad  = val[RadiusW-1:0];
      CFG_HIT_COLOR:  col_hit  = val[ColorW-1:0];
      CFG_MISS_COLOR: col_miss = val[ColorW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_sphere(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                            logic [31:0] rad);
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    write_reg(CFG_CENTER_Z, cz);
    write_reg(CFG_RADIUS, rad);
  endtask

  // Image corners, centre, rows past the bottom edge, all-ones fields
  task automatic test_reset_scene();
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd0, 10'd767);
    send_pixel(10'd1023, 10'd767);
    send_pixel(10'd511, 10'd383);
    send_pixel(10'd512, 10'd384);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd400, 10'd200);
    send_pixel(10'd380, 10'd180);
    send_pixel(10'd682, 10'd341);
    send_pixel(10'd341, 10'd682);
    drain();
  endtask

  // Register extremes: zero and full radius, extreme centres and colours
  task automatic test_reg_extremes();
    write_reg(CFG_HIT_COLOR, 32'h00FF_FFFF);
    write_reg(CFG_MISS_COLOR, 32'h0000_0000);
    set_sphere(32'd0, 32'd0, -32'sd655360, 32'd0);
    send_pixel(10'd511, 10'd383);
    send_pixel(10'd512, 10'd384);
    send_pixel(10'd0, 10'd0);
    drain();
    // sphere around the camera: nearest positive root is t1
    set_sphere(32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    drain();
    write_reg(CFG_HIT_COLOR, 32'h0000_0000);
    write_reg(CFG_MISS_COLOR, 32'h00FF_FFFF);
    // huge centres: distance saturation and wrapped squares
    set_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd0, 10'd1023);
    drain();
    set_sphere(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h4000_0000);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd511, 10'd383);
    drain();
    // centre behind the camera: negative dot product
    set_sphere(32'd0, 32'd0, 32'sd655360, 32'd327680);
    send_pixel(10'd511, 10'd383);
    drain();
  endtask

  task automatic random_sphere();
    logic [31:0] cx, cy, cz, rad;
    if ($urandom_range(9) < 7) begin
      cx  = $signed($urandom_range(1310720)) - 655360;
      cy  = $signed($urandom_range(1310720)) - 655360;
      cz  = -$signed($urandom_range(2000000, 200000));
      rad = $urandom_range(900000, 30000);
    end else begin
      cx  = $urandom;
      cy  = $urandom;
      cz  = $urandom;
      rad = $urandom;
    end
    set_sphere(cx, cy, cz, rad);
    write_reg(CFG_HIT_COLOR, $urandom);
    write_reg(CFG_MISS_COLOR, $urandom);
  endtask

  // Random pixels across several register settings
  task automatic test_random_pixels(int n_items);
    for (int i = 0; i < n_items; i++) begin
      if (i % 250 == 0) begin
        drain();
        random_sphere();
      end
      // one long stretch with no idling on either side
      if (i == 500) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (i == 700) begin
        tx_idle_pct = 16;
        rx_idle_pct = 16;
      end
      send_pixel(ColW'($urandom), RowW'($urandom));
    end
    drain();
  endtask

  // Receiver holds off long enough for the pipe to fill and stall the input
  task automatic test_backpressure();
    tx_idle_pct = 0;
    @(negedge clk_i);
    rx_hold_left = 4 * Latency;
    for (int i = 0; i < 3 * Latency; i++) begin
      send_pixel(ColW'($urandom), RowW'($urandom_range(767)));
    end
    tx_idle_pct = 16;
    drain();
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    out_stall_i  = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_CENTER_X;
    cfg_wdata_i  = '0;
    n_errors     = 0;
    cycle_cnt    = 0;
    tx_idle_pct  = 16;
    rx_idle_pct  = 16;
    rx_hold_left = 0;
    sph_cx   = longint'(CenterXRst);
    sph_cy   = longint'(CenterYRst);
    sph_cz   = longint'(CenterZRst);
    sph_rad  = RadiusRst;
    col_hit  = HitColRst;
    col_miss = MissColRst;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_scene();
    test_reg_extremes();
    test_backpressure();
    test_random_pixels(1200);

    if (n_errors == 0) begin
      $display("[ray_sphere_pixel_caster] OK");
    end else begin
      $display("[ray_sphere_pixel_caster] ERROR");
    end
    $finish;
  end

endmodule

// ----- ray_sphere_pixel_caster.f -----
rtl/rsp_pkg.sv
rtl/rsp_div_pipe.sv
rtl/rsp_isqrt_pipe.sv
rtl/ray_sphere_pixel_caster.sv
rtl/rsp_checker.sv
tb/tb_ray_sphere_pixel_caster.sv
